### src/phcd_pkg.sv
package phcd_pkg;

  // sizing of the waveform and column counters
  localparam int POINT_BITS  = 32;
  localparam int COLUMN_BITS = 16;
  localparam int MAX_RUN     = 64;

  // fixed field widths
  localparam int SAMPLE_BITS    = 8;
  localparam int IDX_BITS       = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = (POINT_BITS > COLUMN_BITS) ? POINT_BITS : COLUMN_BITS;

  // signed boundary difference (c+1)*N - (s+1)*C, kept within [-C, N + C]
  localparam int DIFF_BITS = CFG_DATA_BITS + 3;

  // width for the columns against MAX_RUN * sample count check
  localparam int PROD_BITS = POINT_BITS + $clog2(MAX_RUN) + 1;
  localparam int CMP_BITS  = (PROD_BITS > COLUMN_BITS) ? PROD_BITS : COLUMN_BITS;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_COUNT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMNS     = CFG_INDEX_BITS'(1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_err;
    logic load_col;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_cfg;
    logic emit;
    logic more;
    logic slot_free;
  } dp_status_t;

endpackage

### src/phcd_ctrl.sv
module phcd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  cfg_valid,
  input  phcd_pkg::dp_status_t  status,
  output phcd_pkg::ctl_cmd_t    cmd,
  output logic                  in_stall
);

  phcd_pkg::ctl_state_t state_r, state_nxt;
  logic                 done;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    done         = 1'b0;
    case (state_r)
      phcd_pkg::ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = phcd_pkg::ST_RUN;
        end
      end
      phcd_pkg::ST_RUN: begin
        // one result per cycle while the output register has room
        if (status.bad_cfg) begin
          if (status.slot_free) begin
            cmd.load_err = 1'b1;
            cmd.finish   = 1'b1;
            done         = 1'b1;
          end
        end else if (status.emit) begin
          if (status.slot_free) begin
            cmd.load_col = 1'b1;
            if (!status.more) begin
              cmd.finish = 1'b1;
              done       = 1'b1;
            end
          end
        end else begin
          cmd.finish = 1'b1;
          done       = 1'b1;
        end
        // take the next sample in the cycle this one completes
        if (done) begin
          if (in_valid && !cfg_valid) begin
            cmd.accept = 1'b1;
          end else begin
            state_nxt = phcd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = phcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = cfg_valid || ((state_r == phcd_pkg::ST_RUN) && !done);

endmodule

### src/phcd_datapath.sv
module phcd_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  phcd_pkg::ctl_cmd_t                    cmd,
  output phcd_pkg::dp_status_t                  status,
  input  logic                                  cfg_valid,
  input  logic [phcd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [phcd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_amplitude,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_red,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_green,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_blue,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [phcd_pkg::IDX_BITS-1:0]         out_column_index,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_level,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_red,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_green,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_blue,
  output logic                                  out_last_of_run,
  output logic                                  out_final_column,
  output logic                                  out_config_error
);

  localparam int PB = phcd_pkg::POINT_BITS;
  localparam int CB = phcd_pkg::COLUMN_BITS;
  localparam int DB = phcd_pkg::DIFF_BITS;
  localparam int SB = phcd_pkg::SAMPLE_BITS;
  localparam int MB = phcd_pkg::CMP_BITS;

  // configuration and position state
  logic [PB-1:0]        pc_r, pc_nxt;
  logic [CB-1:0]        col_r, col_nxt;
  logic signed [DB-1:0] nmc_r, nmc_nxt;
  logic [PB-1:0]        s_r, s_nxt;
  logic [CB-1:0]        c_r, c_nxt;
  logic signed [DB-1:0] e_r, e_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload
  logic [SB-1:0] samp_amp_r, samp_red_r, samp_green_r, samp_blue_r;
  logic [SB-1:0] held_level_r, held_red_r, held_green_r, held_blue_r;
  logic [SB-1:0] held_level_nxt, held_red_nxt, held_green_nxt, held_blue_nxt;
  logic [SB-1:0] mp_level, mp_red, mp_green, mp_blue;
  logic [phcd_pkg::IDX_BITS-1:0] o_idx_r;
  logic [SB-1:0] o_level_r, o_red_r, o_green_r, o_blue_r;
  logic          o_last_r, o_final_r, o_err_r;

  logic                 cfg_wr;
  logic [PB-1:0]        pc_new;
  logic [CB-1:0]        col_new;
  logic signed [DB-1:0] n_ext, c_ext, nmc_new;
  logic [MB-1:0]        col_wide, run_limit;
  logic                 take_samp, e_neg, final_col, last_sample, slot_free, advance;

  // register write decode
  assign cfg_wr  = cfg_valid && ((cfg_index == phcd_pkg::REG_POINT_COUNT) ||
                                 (cfg_index == phcd_pkg::REG_COLUMNS));
  assign pc_new  = (cfg_index == phcd_pkg::REG_POINT_COUNT) ? cfg_data[PB-1:0] : pc_r;
  assign col_new = (cfg_index == phcd_pkg::REG_COLUMNS) ? cfg_data[CB-1:0] : col_r;
  assign nmc_new = $signed(DB'(pc_new)) - $signed(DB'(col_new));

  assign n_ext = $signed(DB'(pc_r));
  assign c_ext = $signed(DB'(col_r));

  // bad configuration: no columns, or more than MAX_RUN columns per sample
  assign col_wide  = MB'(col_r);
  assign run_limit = MB'(pc_r) * MB'(phcd_pkg::MAX_RUN);

  // running peak merged with the held sample
  assign take_samp = !held_valid_r || (samp_amp_r > held_level_r);
  assign mp_level  = take_samp ? samp_amp_r   : held_level_r;
  assign mp_red    = take_samp ? samp_red_r   : held_red_r;
  assign mp_green  = take_samp ? samp_green_r : held_green_r;
  assign mp_blue   = take_samp ? samp_blue_r  : held_blue_r;

  // column boundary tests on the signed difference
  assign e_neg       = e_r[DB-1];
  assign final_col   = (({1'b0, c_r} + (CB+1)'(1)) == {1'b0, col_r});
  assign last_sample = (({1'b0, s_r} + (PB+1)'(1)) >= {1'b0, pc_r});
  assign slot_free   = !out_valid_r || !out_stall;
  assign advance     = cmd.finish && !cmd.load_err;

  always_comb begin
    status.bad_cfg   = (col_r == '0) || (col_wide > run_limit);
    status.emit      = (!e_neg && (e_r < c_ext)) || (e_neg && (e_r >= nmc_r));
    status.more      = e_neg && !final_col;
    status.slot_free = slot_free;
  end

  // next position state
  always_comb begin
    pc_nxt         = pc_r;
    col_nxt        = col_r;
    nmc_nxt        = nmc_r;
    s_nxt          = s_r;
    c_nxt          = c_r;
    e_nxt          = e_r;
    held_valid_nxt = held_valid_r;
    held_level_nxt = held_level_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    held_blue_nxt  = held_blue_r;
    if (cfg_wr) begin
      pc_nxt         = pc_new;
      col_nxt        = col_new;
      nmc_nxt        = nmc_new;
      s_nxt          = '0;
      c_nxt          = '0;
      e_nxt          = nmc_new;
      held_valid_nxt = 1'b0;
    end else begin
      if (cmd.load_col) begin
        c_nxt          = c_r + CB'(1);
        held_valid_nxt = 1'b0;
        e_nxt          = cmd.finish ? (e_r + nmc_r) : (e_r + n_ext);
      end else if (advance) begin
        held_level_nxt = mp_level;
        held_red_nxt   = mp_red;
        held_green_nxt = mp_green;
        held_blue_nxt  = mp_blue;
        held_valid_nxt = 1'b1;
        e_nxt          = e_r - c_ext;
      end
      // end of the waveform starts again at the first sample
      if (advance) begin
        if (last_sample) begin
          s_nxt          = '0;
          c_nxt          = '0;
          e_nxt          = nmc_r;
          held_valid_nxt = 1'b0;
        end else begin
          s_nxt = s_r + PB'(1);
        end
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_col || cmd.load_err) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PB'(1);
      col_r        <= CB'(1);
      nmc_r        <= '0;
      s_r          <= '0;
      c_r          <= '0;
      e_r          <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      col_r        <= col_nxt;
      nmc_r        <= nmc_nxt;
      s_r          <= s_nxt;
      c_r          <= c_nxt;
      e_r          <= e_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // sample, held peak and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp_amp_r   <= in_amplitude;
      samp_red_r   <= in_red;
      samp_green_r <= in_green;
      samp_blue_r  <= in_blue;
    end
    held_level_r <= held_level_nxt;
    held_red_r   <= held_red_nxt;
    held_green_r <= held_green_nxt;
    held_blue_r  <= held_blue_nxt;
    if (cmd.load_err) begin
      o_idx_r   <= '0;
      o_level_r <= '0;
      o_red_r   <= '0;
      o_green_r <= '0;
      o_blue_r  <= '0;
      o_last_r  <= 1'b0;
      o_final_r <= 1'b0;
      o_err_r   <= 1'b1;
    end else if (cmd.load_col) begin
      o_idx_r   <= phcd_pkg::IDX_BITS'(c_r);
      o_level_r <= mp_level;
      o_red_r   <= mp_red;
      o_green_r <= mp_green;
      o_blue_r  <= mp_blue;
      o_last_r  <= cmd.finish;
      o_final_r <= final_col;
      o_err_r   <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = o_idx_r;
  assign out_peak_level   = o_level_r;
  assign out_peak_red     = o_red_r;
  assign out_peak_green   = o_green_r;
  assign out_peak_blue    = o_blue_r;
  assign out_last_of_run  = o_last_r;
  assign out_final_column = o_final_r;
  assign out_config_error = o_err_r;

endmodule

### src/peak_hold_column_decimator_top.sv
// peak hold column decimator: reduces a waveform of a set number of samples to
// columns results, each the peak amplitude of its column with that sample's colour
// input channel: in_valid / in_stall with amplitude and colour, one sample per request
// result channel: out_valid / out_stall, one column peak or one error per request
// config channel: cfg_valid / cfg_ready (always ready), index 0 sample count, 1 columns;
// a write restarts the waveform and drops any held peak
// throughput: one sample per cycle while the output register has room, no config write
// is offered and each sample closes at most one column; a sample closing k columns
// is held until all k of its results are loaded into the output register
// reset: sample count and columns return to 1, position returns to sample 0, column 0
// stall: the output register holds its result; the sample in hand waits for room,
// and in_stall rises until its last result is loaded
// a bad setting (columns zero or above 64 times the sample count) gives one error
// result per sample with all other fields zero
module peak_hold_column_decimator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_amplitude,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_red,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_green,
  input  logic [phcd_pkg::SAMPLE_BITS-1:0]      in_blue,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [phcd_pkg::IDX_BITS-1:0]         out_column_index,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_level,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_red,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_green,
  output logic [phcd_pkg::SAMPLE_BITS-1:0]      out_peak_blue,
  output logic                                  out_last_of_run,
  output logic                                  out_final_column,
  output logic                                  out_config_error,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [phcd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [phcd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  phcd_pkg::ctl_cmd_t   cmd;
  phcd_pkg::dp_status_t status;

  // registers are taken whenever offered
  assign cfg_ready = 1'b1;

  phcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  phcd_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_amplitude     (in_amplitude),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_column_index (out_column_index),
    .out_peak_level   (out_peak_level),
    .out_peak_red     (out_peak_red),
    .out_peak_green   (out_peak_green),
    .out_peak_blue    (out_peak_blue),
    .out_last_of_run  (out_last_of_run),
    .out_final_column (out_final_column),
    .out_config_error (out_config_error)
  );

`ifndef SYNTHESIS
  // an error result carries a zero index and level and no last or final flag
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_config_error) |->
      (out_column_index == '0) && (out_peak_level == '0) && !out_last_of_run &&
      !out_final_column)
    else $error("error result with non-zero fields");

  // the last column of the waveform always ends its sample's run
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_column) |-> out_last_of_run)
    else $error("final column not marked last of run");

  // only one of error and column result is loaded at a time
  a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_err && cmd.load_col))
    else $error("error and column result loaded together");
`endif

endmodule
